/* design/fhm_pkg.sv */
// Package for the frame interval hitch monitor: command and reason codes, register
// indexes, reset values, the item and result types and saturating counter helpers.
// No dependencies.
package fhm_pkg;

  localparam int TimeW    = 32;
  localparam int WinTimeW = 33;
  localparam int HitchSumW = 48;
  localparam int PendW    = 16;
  localparam int CfgIdxW  = 2;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_FLUSH   = 2'd1,
    CMD_LOAD    = 2'd2,
    CMD_REQUEST = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    RSN_WINDOW  = 2'd0,
    RSN_LOAD    = 2'd1,
    RSN_REQUEST = 2'd2
  } reason_t;

  localparam logic [CfgIdxW-1:0] CFG_HITCH_THRESHOLD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_STALL_CEILING   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SUMMARY_WINDOW  = 2'd2;

  localparam logic [TimeW-1:0] HITCH_THRESHOLD_RST = 32'd50000;
  localparam logic [TimeW-1:0] STALL_CEILING_RST   = 32'd1000000;
  localparam logic [TimeW-1:0] SUMMARY_WINDOW_RST  = 32'd60000000;

  typedef struct packed {
    logic             valid;
    cmd_t             command;
    logic [TimeW-1:0] timestamp_us;
  } item_t;

  typedef struct packed {
    reason_t              summary_reason;
    logic [TimeW-1:0]     frames_in_window;
    logic [WinTimeW-1:0]  window_time_us;
    logic [TimeW-1:0]     hitch_count;
    logic [TimeW-1:0]     hitches_with_flush;
    logic [TimeW-1:0]     stall_count;
    logic [TimeW-1:0]     worst_hitch_us;
    logic [HitchSumW-1:0] hitch_time_sum_us;
    logic [TimeW-1:0]     flushes_in_session;
    logic [TimeW-1:0]     session_hitch_count;
    logic [TimeW-1:0]     session_worst_us;
  } result_t;

  function automatic logic [TimeW-1:0] sat_inc32(input logic [TimeW-1:0] x);
    return (&x) ? x : x + 1'b1;
  endfunction

  function automatic logic [PendW-1:0] sat_inc16(input logic [PendW-1:0] x);
    return (&x) ? x : x + 1'b1;
  endfunction

endpackage

/* design/fhm_in_if.sv */
// Event channel: valid/ready handshake carrying command and timestamp.
// Depends on nothing.
interface fhm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] timestamp_us;

  modport source (output valid, output command, output timestamp_us, input ready);
  modport sink   (input valid, input command, input timestamp_us, output ready);
endinterface

/* design/fhm_out_if.sv */
// Summary channel: valid/ready handshake carrying one window summary.
// Depends on nothing.
interface fhm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  summary_reason;
  logic [31:0] frames_in_window;
  logic [32:0] window_time_us;
  logic [31:0] hitch_count;
  logic [31:0] hitches_with_flush;
  logic [31:0] stall_count;
  logic [31:0] worst_hitch_us;
  logic [47:0] hitch_time_sum_us;
  logic [31:0] flushes_in_session;
  logic [31:0] session_hitch_count;
  logic [31:0] session_worst_us;

  modport source (
    output valid, output summary_reason, output frames_in_window, output window_time_us,
    output hitch_count, output hitches_with_flush, output stall_count, output worst_hitch_us,
    output hitch_time_sum_us, output flushes_in_session, output session_hitch_count,
    output session_worst_us, input ready
  );
  modport sink (
    input valid, input summary_reason, input frames_in_window, input window_time_us,
    input hitch_count, input hitches_with_flush, input stall_count, input worst_hitch_us,
    input hitch_time_sum_us, input flushes_in_session, input session_hitch_count,
    input session_worst_us, output ready
  );
endinterface

/* design/fhm_in_reg.sv */
// Input register stage of the hitch monitor: captures one event transaction.
// Depends on fhm_pkg and fhm_in_if.
module fhm_in_reg (
  input  logic           clk,
  input  logic           rst,
  fhm_in_if.sink         events,
  input  logic           take,
  output fhm_pkg::item_t item
);
  import fhm_pkg::*;

  item_t held;
  logic  accept;

  assign events.ready = !held.valid || take;
  assign accept       = events.valid && events.ready;
  assign item         = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
    end else if (accept) begin
      held.valid <= 1'b1;
    end else if (take) begin
      held.valid <= 1'b0;
    end
    if (accept) begin
      held.command      <= cmd_t'(events.command);
      held.timestamp_us <= events.timestamp_us;
    end
  end

endmodule

/* design/fhm_core.sv */
// Hitch monitor core: configuration registers, window and session state, one-pass
// event update and the summary result register. Depends on fhm_pkg and fhm_out_if.
module fhm_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fhm_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [fhm_pkg::TimeW-1:0]     cfg_data,
  input  fhm_pkg::item_t                item,
  output logic                          take,
  fhm_out_if.source                     summary
);
  import fhm_pkg::*;

  logic [TimeW-1:0] hitch_threshold;
  logic [TimeW-1:0] stall_ceiling;
  logic [TimeW-1:0] summary_window;

  logic                 primed, primed_next;
  logic [TimeW-1:0]     last_tick, last_tick_next;
  logic [PendW-1:0]     pending, pending_next;
  logic [TimeW-1:0]     session_flushes, session_flushes_next;
  logic [TimeW-1:0]     total_frames, total_frames_next;
  logic [TimeW-1:0]     win_frames, win_frames_next;
  logic [WinTimeW-1:0]  win_time, win_time_next;
  logic [TimeW-1:0]     win_hitches, win_hitches_next;
  logic [TimeW-1:0]     win_flush_hitches, win_flush_hitches_next;
  logic [TimeW-1:0]     win_stalls, win_stalls_next;
  logic [TimeW-1:0]     win_worst, win_worst_next;
  logic [HitchSumW-1:0] win_hitch_sum, win_hitch_sum_next;
  logic [TimeW-1:0]     session_hitches, session_hitches_next;
  logic [TimeW-1:0]     session_worst, session_worst_next;

  logic                 res_valid;
  result_t              res, res_next;
  logic                 emit;
  reason_t              reason;

  logic [TimeW-1:0]       dt;
  logic [WinTimeW:0]      wt_sum;
  logic [HitchSumW:0]     hs_sum;
  logic [WinTimeW-1:0]    wt_upd;
  logic [HitchSumW-1:0]   hs_upd;
  logic                   is_stall, is_hitch;

  assign take = item.valid && (!res_valid || summary.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      hitch_threshold <= HITCH_THRESHOLD_RST;
      stall_ceiling   <= STALL_CEILING_RST;
      summary_window  <= SUMMARY_WINDOW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HITCH_THRESHOLD: hitch_threshold <= cfg_data;
        CFG_STALL_CEILING:   stall_ceiling   <= cfg_data;
        CFG_SUMMARY_WINDOW:  summary_window  <= cfg_data;
        default: ;
      endcase
    end
  end

  // interval arithmetic: dt wraps modulo 2^32, the window sums saturate
  assign dt       = item.timestamp_us - last_tick;
  assign wt_sum   = {1'b0, win_time} + {{(WinTimeW + 1 - TimeW){1'b0}}, dt};
  assign wt_upd   = wt_sum[WinTimeW] ? {WinTimeW{1'b1}} : wt_sum[WinTimeW-1:0];
  assign hs_sum   = {1'b0, win_hitch_sum} + {{(HitchSumW + 1 - TimeW){1'b0}}, dt};
  assign hs_upd   = hs_sum[HitchSumW] ? {HitchSumW{1'b1}} : hs_sum[HitchSumW-1:0];
  assign is_stall = dt >= stall_ceiling;
  assign is_hitch = !is_stall && (dt >= hitch_threshold);

  always_comb begin
    primed_next            = primed;
    last_tick_next         = last_tick;
    pending_next           = pending;
    session_flushes_next   = session_flushes;
    total_frames_next      = total_frames;
    win_frames_next        = win_frames;
    win_time_next          = win_time;
    win_hitches_next       = win_hitches;
    win_flush_hitches_next = win_flush_hitches;
    win_stalls_next        = win_stalls;
    win_worst_next         = win_worst;
    win_hitch_sum_next     = win_hitch_sum;
    session_hitches_next   = session_hitches;
    session_worst_next     = session_worst;
    emit                   = 1'b0;
    reason                 = RSN_REQUEST;

    case (item.command)
      CMD_FLUSH: begin
        pending_next         = sat_inc16(pending);
        session_flushes_next = sat_inc32(session_flushes);
      end
      CMD_LOAD: begin
        primed_next = 1'b0;
        emit        = total_frames != '0;
        reason      = RSN_LOAD;
      end
      CMD_REQUEST: begin
        emit   = 1'b1;
        reason = RSN_REQUEST;
      end
      CMD_TICK: begin
        last_tick_next = item.timestamp_us;
        pending_next   = '0;
        primed_next    = 1'b1;
        if (primed) begin
          win_frames_next   = sat_inc32(win_frames);
          total_frames_next = sat_inc32(total_frames);
          win_time_next     = wt_upd;
          if (is_stall) begin
            win_stalls_next = sat_inc32(win_stalls);
          end
          if (is_hitch) begin
            win_hitches_next     = sat_inc32(win_hitches);
            session_hitches_next = sat_inc32(session_hitches);
            win_hitch_sum_next   = hs_upd;
            if (dt > win_worst) begin
              win_worst_next = dt;
            end
            if (dt > session_worst) begin
              session_worst_next = dt;
            end
            if (pending != '0) begin
              win_flush_hitches_next = sat_inc32(win_flush_hitches);
            end
          end
          emit   = wt_upd >= {1'b0, summary_window};
          reason = RSN_WINDOW;
        end
      end
      default: ;
    endcase

    res_next.summary_reason      = reason;
    res_next.frames_in_window    = win_frames_next;
    res_next.window_time_us      = win_time_next;
    res_next.hitch_count         = win_hitches_next;
    res_next.hitches_with_flush  = win_flush_hitches_next;
    res_next.stall_count         = win_stalls_next;
    res_next.worst_hitch_us      = win_worst_next;
    res_next.hitch_time_sum_us   = win_hitch_sum_next;
    res_next.flushes_in_session  = session_flushes_next;
    res_next.session_hitch_count = session_hitches_next;
    res_next.session_worst_us    = session_worst_next;

    if (emit) begin
      win_frames_next        = '0;
      win_time_next          = '0;
      win_hitches_next       = '0;
      win_flush_hitches_next = '0;
      win_stalls_next        = '0;
      win_worst_next         = '0;
      win_hitch_sum_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed            <= 1'b0;
      last_tick         <= '0;
      pending           <= '0;
      session_flushes   <= '0;
      total_frames      <= '0;
      win_frames        <= '0;
      win_time          <= '0;
      win_hitches       <= '0;
      win_flush_hitches <= '0;
      win_stalls        <= '0;
      win_worst         <= '0;
      win_hitch_sum     <= '0;
      session_hitches   <= '0;
      session_worst     <= '0;
    end else if (take) begin
      primed            <= primed_next;
      last_tick         <= last_tick_next;
      pending           <= pending_next;
      session_flushes   <= session_flushes_next;
      total_frames      <= total_frames_next;
      win_frames        <= win_frames_next;
      win_time          <= win_time_next;
      win_hitches       <= win_hitches_next;
      win_flush_hitches <= win_flush_hitches_next;
      win_stalls        <= win_stalls_next;
      win_worst         <= win_worst_next;
      win_hitch_sum     <= win_hitch_sum_next;
      session_hitches   <= session_hitches_next;
      session_worst     <= session_worst_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= emit;
    end else if (summary.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      res <= res_next;
    end
  end

  assign summary.valid               = res_valid;
  assign summary.summary_reason      = res.summary_reason;
  assign summary.frames_in_window    = res.frames_in_window;
  assign summary.window_time_us      = res.window_time_us;
  assign summary.hitch_count         = res.hitch_count;
  assign summary.hitches_with_flush  = res.hitches_with_flush;
  assign summary.stall_count         = res.stall_count;
  assign summary.worst_hitch_us      = res.worst_hitch_us;
  assign summary.hitch_time_sum_us   = res.hitch_time_sum_us;
  assign summary.flushes_in_session  = res.flushes_in_session;
  assign summary.session_hitch_count = res.session_hitch_count;
  assign summary.session_worst_us    = res.session_worst_us;

endmodule

/* design/frame_interval_hitch_monitor.sv */
// Frame interval hitch monitor, top level.
// An accepted event is held in the input register, and its summary is then registered in
// the summary result register when the core takes the event from the input register.
// Throughput: one event per cycle; the core stalls only while a summary waits on the
// receiver, and the state update uses 34/49-bit saturating adds and compares.
// Reset (synchronous, rst high) clears all counters and restores the default thresholds.
// Depends on fhm_pkg, fhm_in_if, fhm_out_if, fhm_in_reg and fhm_core.
module frame_interval_hitch_monitor (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [fhm_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [fhm_pkg::TimeW-1:0]   cfg_data,
  fhm_in_if.sink                      events,
  fhm_out_if.source                   summary
);
  import fhm_pkg::*;

  item_t item;
  logic  take;

  fhm_in_reg u_in_reg (
    .clk    (clk),
    .rst    (rst),
    .events (events),
    .take   (take),
    .item   (item)
  );

  fhm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .take      (take),
    .summary   (summary)
  );

endmodule
